// ----- rtl/wzn_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package wzn_pkg;
  localparam int SampleW = 12;
  localparam int ZW = 16;
  localparam int PosW = 6;
  localparam int WindowDefault = 64;
  localparam int SumW = 18;
  localparam int SqW = 30;
  localparam int DW = 37;
  localparam int RootW = 31;
  localparam int MagW = 19;
endpackage
`default_nettype wire

// ----- rtl/wzn_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
interface wzn_in_if;
  logic valid;
  logic ready;
  logic [wzn_pkg::SampleW-1:0] sample;
  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface wzn_out_if;
  logic valid;
  logic ready;
  logic signed [wzn_pkg::ZW-1:0] z_score;
  logic [wzn_pkg::PosW-1:0] position;
  logic last;
  modport source (output valid, output z_score, output position, output last, input ready);
  modport sink (input valid, input z_score, input position, input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/wzn_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Collect the window: store samples, keep sums, compute the root at fill.
module wzn_front #(
  parameter int WINDOW = wzn_pkg::WindowDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  wzn_in_if.sink in,
  input  wire logic busy,
  input  wire logic [5:0] rd_addr,
  output logic [wzn_pkg::SampleW-1:0] rd_data,
  output logic job_valid,
  input  wire logic job_take,
  output logic [wzn_pkg::MagW-1:0] job_s,
  output logic [wzn_pkg::RootW-1:0] job_r
);
  localparam logic [6:0] WinC = 7'(WINDOW);
  localparam logic [1:0] StCollect = 2'd0;
  localparam logic [1:0] StRoot = 2'd1;
  localparam logic [1:0] StHand = 2'd2;
  localparam logic [1:0] StLoad = 2'd3;
  localparam int RootWX = wzn_pkg::RootW;
  localparam int SumW = wzn_pkg::SumW;

  logic [wzn_pkg::SampleW-1:0] mem [0:63];
  logic [1:0] state;
  logic [6:0] fill_count;
  logic [wzn_pkg::SumW-1:0] running_sum;
  logic [wzn_pkg::SqW-1:0] running_square_sum;
  logic [5:0] step;
  logic [61:0] rem;
  logic [61:0] opnd;
  logic [RootWX-1:0] root;
  logic [31:0] sq_mul;
  logic [33:0] trial;
  logic [63:0] rem_sh;

  // hold off new samples while the back end still reads the stored window
  assign in.ready = (state == StCollect) && !busy;
  assign job_valid = (state == StHand);
  assign sq_mul = 32'(in.sample) * 32'(in.sample);

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    if (in.valid && in.ready) mem[fill_count[5:0]] <= in.sample;
  end

  // one result bit a cycle, two operand bits consumed
  always_comb begin
    rem_sh = {rem, opnd[61:60]};
    trial = {root, 2'b01} + 34'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StCollect;
      fill_count <= '0;
      running_sum <= '0;
      running_square_sum <= '0;
    end else begin
      case (state)
        StCollect: begin
          if (in.valid && in.ready) begin
            running_sum <= running_sum + SumW'(in.sample);
            running_square_sum <= running_square_sum + wzn_pkg::SqW'(sq_mul);
            if (fill_count + 7'd1 == WinC) begin
              state <= StLoad;
              fill_count <= '0;
            end else begin
              fill_count <= fill_count + 7'd1;
            end
          end
        end
        StLoad: state <= StRoot;
        StRoot: begin
          if (step == 6'd30) state <= StHand;
        end
        StHand: begin
          if (job_take) begin
            state <= StCollect;
            running_sum <= '0;
            running_square_sum <= '0;
          end
        end
        default: state <= StCollect;
      endcase
    end
  end

  // D and root payload
  logic [wzn_pkg::DW-1:0] nq, ss, dd;
  always_comb begin
    nq = wzn_pkg::DW'(running_square_sum) * wzn_pkg::DW'(WINDOW);
    ss = wzn_pkg::DW'(running_sum) * wzn_pkg::DW'(running_sum);
    dd = (nq > ss) ? nq - ss : '0;
  end

  // load D<<24 once the sums include the last sample, then 31 root steps
  always_ff @(posedge clk) begin
    if (state == StLoad) begin
      step <= '0;
      opnd <= {1'b0, dd, 24'd0};
      rem <= '0;
      root <= '0;
    end else if (state == StRoot) begin
      step <= step + 6'd1;
      opnd <= {opnd[59:0], 2'b00};
      if (rem_sh[63:0] >= 64'(trial)) begin
        rem <= 62'(rem_sh - 64'(trial));
        root <= {root[RootWX-2:0], 1'b1};
      end else begin
        rem <= 62'(rem_sh);
        root <= {root[RootWX-2:0], 1'b0};
      end
    end
  end
  assign job_s = wzn_pkg::MagW'(running_sum);
  assign job_r = root;
endmodule
`default_nettype wire

// ----- rtl/wzn_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Walk the stored window, divide each deviation by the root, saturate.
module wzn_back #(
  parameter int WINDOW = wzn_pkg::WindowDefault
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  output logic job_take,
  output logic busy,
  input  wire logic [wzn_pkg::MagW-1:0] job_s,
  input  wire logic [wzn_pkg::RootW-1:0] job_r,
  output logic [5:0] rd_addr,
  input  wire logic [wzn_pkg::SampleW-1:0] rd_data,
  wzn_out_if.source out
);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRead = 2'd1;
  localparam logic [1:0] StDiv = 2'd2;
  localparam logic [1:0] StOut = 2'd3;
  localparam int NumW = 45;
  localparam int DenW = 32;

  logic [1:0] state;
  logic [5:0] k;
  logic [wzn_pkg::MagW-1:0] s;
  logic [wzn_pkg::RootW-1:0] r;
  logic neg;
  logic [NumW-1:0] quo;
  logic [DenW:0] rem;
  logic [5:0] cnt;
  logic [DenW+1:0] rsh;
  logic [DenW:0] den;
  logic [24:0] nx;
  logic [24:0] mag;

  assign job_take = job_valid && (state == StIdle);
  assign busy = (state != StIdle);
  // fetch the next sample while the current word waits, so StRead sees it
  assign rd_addr = (state == StOut) ? k + 6'd1 : k;
  assign den = {r, 1'b0} + 33'd0;
  assign nx = 25'(rd_data) * 25'(WINDOW);
  assign mag = (nx < 25'(s)) ? 25'(s) - nx : nx - 25'(s);
  assign rsh = {rem, quo[NumW-1]};
  assign out.valid = (state == StOut);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= StIdle;
    end else begin
      case (state)
        StIdle: if (job_valid) state <= StRead;
        StRead: state <= StDiv;
        StDiv: if (cnt == 6'(NumW - 1)) state <= StOut;
        StOut: begin
          if (out.ready) state <= (k == 6'(WINDOW - 1)) ? StIdle : StRead;
        end
        default: state <= StIdle;
      endcase
    end
  end

  // restoring divide of (mag<<25)+r by 2r, one quotient bit a cycle
  always_ff @(posedge clk) begin
    case (state)
      StIdle: begin
        k <= '0;
        s <= job_s;
        r <= job_r;
      end
      StRead: begin
        cnt <= '0;
        neg <= nx < 25'(s);
        quo <= NumW'({mag, 25'd0}) + NumW'(r);
        rem <= '0;
      end
      StDiv: begin
        cnt <= cnt + 6'd1;
        if (rsh >= 34'(den)) begin
          rem <= 33'(rsh - 34'(den));
          quo <= {quo[NumW-2:0], 1'b1};
        end else begin
          rem <= 33'(rsh);
          quo <= {quo[NumW-2:0], 1'b0};
        end
      end
      StOut: if (out.ready) k <= k + 6'd1;
      default: ;
    endcase
  end

  always_comb begin
    if (r == '0) out.z_score = '0;
    else if (neg) out.z_score = (quo >= 45'd32768) ? 16'sh8000 : 16'(-quo[15:0]);
    else out.z_score = (quo >= 45'd32767) ? 16'sh7fff : 16'(quo[15:0]);
  end
  assign out.position = k;
  assign out.last = (k == 6'(WINDOW - 1));
endmodule
`default_nettype wire

// ----- rtl/window_zscore_normalizer.sv -----
`timescale 1ns / 1ps
`default_nettype none
// The path from the accept of a window's last sample to the first z-score
// runs through load, 31 root steps, handoff, read and 45 divide steps.
// The back end works on one z-score at a time: a read, a 45-step divide,
// then an output word held until the receiver is ready. Input stalls from
// the last sample of a window until its last z-score is taken.
// Reset (rst, synchronous): empties the window and both sums.
module window_zscore_normalizer #(
  parameter int WINDOW = wzn_pkg::WindowDefault
) (
  input wire logic clk,
  input wire logic rst,
  wzn_in_if.sink in,
  wzn_out_if.source out
);
  logic [5:0] rd_addr;
  logic [wzn_pkg::SampleW-1:0] rd_data;
  logic job_valid, job_take, busy;
  logic [wzn_pkg::MagW-1:0] job_s;
  logic [wzn_pkg::RootW-1:0] job_r;

  // front: collect window, sums and root; hold input while the back end runs
  wzn_front #(.WINDOW(WINDOW)) u_front (
    .clk, .rst, .in, .busy, .rd_addr, .rd_data, .job_valid, .job_take, .job_s, .job_r
  );

  // back: replay window through the divider
  wzn_back #(.WINDOW(WINDOW)) u_back (
    .clk, .rst, .job_valid, .job_take, .busy, .job_s, .job_r, .rd_addr, .rd_data, .out
  );

  // a window handoff never happens while results are still going out
  a_take: assert property (@(posedge clk) disable iff (rst)
    job_take |-> !out.valid) else $error("handoff during output");
  // last marks the final position
  a_last: assert property (@(posedge clk) disable iff (rst)
    (out.valid && out.last) |-> (out.position == 6'(WINDOW - 1)))
    else $error("last misplaced");
endmodule
`default_nettype wire
